>>> rtl/stmv_pkg.sv
// Package for the sparse triplet matrix-vector multiply block.
// Holds field widths, opcodes, register indexes, the sequencer state type and
// the control struct for the multiply-accumulate datapath. It depends on nothing.
package stmv_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned OPC_W   = 2;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned ACC_W   = 48;
  localparam int unsigned PROD_W  = 64;
  // Index width used for range checks against depths up to 65536.
  localparam int unsigned EXT_W   = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 1;

  // Rounding offset for the Q32.32 to Q32.16 step (one half LSB).
  localparam logic signed [PROD_W-1:0] ROUND_HALF = 64'sd32768;
  localparam int unsigned FRAC_SHIFT = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SYMMETRIC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEGATE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE = 2'd2;

  typedef enum logic [OPC_W-1:0] {
    OP_LOAD_VEC  = 2'd0,
    OP_SET_ACC   = 2'd1,
    OP_TRIPLET   = 2'd2,
    OP_READ_ACC  = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TR_READ,
    S_TR_MUL,
    S_TR_RND,
    S_TR_ADD,
    S_RD_WAIT
  } state_e;

  // Stage enables for the multiply-accumulate datapath.
  typedef struct packed {
    logic mul_en;
    logic rnd_en;
    logic negate;
  } mac_ctrl_t;

endpackage

>>> rtl/stmv_if.sv
// Valid/ready channel interfaces for the sparse triplet matrix-vector multiply.
// One interface carries input items, the other carries read result items.
// Depends on stmv_pkg for the field widths.
interface stmv_in_if;
  logic                             valid;
  logic                             ready;
  logic [stmv_pkg::OPC_W-1:0]       opcode;
  logic [stmv_pkg::IDX_W-1:0]       row_index;
  logic [stmv_pkg::IDX_W-1:0]       column_index;
  logic signed [stmv_pkg::VAL_W-1:0] operand_value;

  modport source (output valid, output opcode, output row_index, output column_index,
                  output operand_value, input ready);
  modport sink (input valid, input opcode, input row_index, input column_index,
                input operand_value, output ready);
endinterface

interface stmv_out_if;
  logic                              valid;
  logic                              ready;
  logic [stmv_pkg::IDX_W-1:0]        read_index;
  logic signed [stmv_pkg::ACC_W-1:0] read_value;

  modport source (output valid, output read_index, output read_value, input ready);
  modport sink (input valid, input read_index, input read_value, output ready);
endinterface

>>> rtl/stmv_ram.sv
// Simple dual-port synchronous RAM: one write and one read port per cycle.
// Read data is registered and holds until the next read enable.
// Stand-alone; used for the vector store and the accumulator store.
module stmv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/stmv_mac.sv
// Multiply, round and saturating-add datapath of the triplet update.
// Stage one registers the Q32.32 product, stage two the rounded and signed term;
// the saturated sum is combinational from the term and the accumulator entry.
module stmv_mac (
  input  logic                              clk_i,
  input  stmv_pkg::mac_ctrl_t               ctrl_i,
  input  logic signed [stmv_pkg::VAL_W-1:0] value_i,
  input  logic signed [stmv_pkg::VAL_W-1:0] vec_i,
  input  logic signed [stmv_pkg::ACC_W-1:0] acc_i,
  output logic signed [stmv_pkg::ACC_W-1:0] sum_o
);
  import stmv_pkg::*;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  term_d;
  logic signed [ACC_W-1:0]  term_q;
  logic signed [ACC_W:0]    sum_wide;

  // Product of the matrix value and the vector entry, exact in 64 bits.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= PROD_W'(value_i) * PROD_W'(vec_i);
    end
  end

  // Round to nearest with ties toward plus infinity; the term magnitude stays
  // within 2^46, so 48 bits hold it and its negation.
  assign prod_rnd = prod_q + ROUND_HALF;
  assign term     = prod_rnd[FRAC_SHIFT +: ACC_W];
  assign term_d   = ctrl_i.negate ? -term : term;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rnd_en) begin
      term_q <= term_d;
    end
  end

  // Saturating accumulate to the 48-bit range.
  assign sum_wide = {acc_i[ACC_W-1], acc_i} + {term_q[ACC_W-1], term_q};

  always_comb begin
    if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
      sum_o = sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sum_o = sum_wide[ACC_W-1:0];
    end
  end

endmodule

>>> rtl/sparse_triplet_matrix_vector_multiply.sv
// Sparse triplet matrix-vector multiply, top level.
// Input items arrive on in_i (valid/ready); read results leave on out_o.
// Opcodes: load a vector entry, set an accumulator entry, apply a triplet
// (row, column, value), or read an accumulator entry. Configuration is written
// through cfg_we_i / cfg_index_i / cfg_data_i; the user must do so only while the
// block is idle, as the block itself does not enforce it. A load or a set is
// taken on accept. A read passes the accumulator RAM read, then the output
// register. A triplet steps through accept, RAM read, multiply, round and write
// back for each accumulator update; a symmetric off-diagonal triplet makes two
// updates. Between read and write back of the same accumulator entry lie the
// RAM read data register and the two datapath stages.
// The output register holds a result until it is taken; the next item is
// accepted meanwhile, and a further read waits in its RAM-data state until the
// register frees up. Reset clears the configuration registers and the
// sequencer; neither RAM is cleared, so entries must be written before use.
module sparse_triplet_matrix_vector_multiply #(
  parameter int unsigned VECTOR_DEPTH      = 1024,
  parameter int unsigned ACCUMULATOR_DEPTH = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [stmv_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [stmv_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  stmv_in_if.sink                              in_i,
  stmv_out_if.source                           out_o
);
  import stmv_pkg::*;

  localparam int unsigned VAW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
  localparam int unsigned AAW = (ACCUMULATOR_DEPTH > 1) ? $clog2(ACCUMULATOR_DEPTH) : 1;
  localparam logic [EXT_W-1:0] VEC_LIMIT = EXT_W'(VECTOR_DEPTH);
  localparam logic [EXT_W-1:0] ACC_LIMIT = EXT_W'(ACCUMULATOR_DEPTH);

  state_e state_q, state_d;

  logic sym_q, neg_q, trn_q;
  logic pass_q, pass_d;
  logic rd_ok_q;
  logic [IDX_W-1:0] row_q, col_q;
  logic signed [VAL_W-1:0] value_q;

  logic out_valid_q, out_valid_d;
  logic [IDX_W-1:0] out_index_q;
  logic signed [ACC_W-1:0] out_value_q;

  logic accept, out_free, out_load, second_pass;
  opcode_e in_op;
  logic [EXT_W-1:0] in_row_ext;
  logic in_vec_ok, in_acc_ok;

  logic swap;
  logic [IDX_W-1:0] dst_idx, src_idx;
  logic [EXT_W-1:0] dst_ext, src_ext;
  logic pass_ok;

  logic vec_we, vec_re, acc_we, acc_re;
  logic [VAW-1:0] vec_waddr;
  logic [AAW-1:0] acc_waddr, acc_raddr;
  logic [ACC_W-1:0] acc_wdata;
  logic [VAL_W-1:0] vec_rdata;
  logic [ACC_W-1:0] acc_rdata;
  logic signed [ACC_W-1:0] mac_sum;
  mac_ctrl_t mac_ctrl;

  // Handshake and input decode.
  assign accept     = in_i.valid && in_i.ready;
  assign in_op      = opcode_e'(in_i.opcode);
  assign in_row_ext = EXT_W'(in_i.row_index);
  assign in_vec_ok  = in_row_ext < VEC_LIMIT;
  assign in_acc_ok  = in_row_ext < ACC_LIMIT;
  assign out_free   = !out_valid_q || out_o.ready;

  // Destination and source of the current update pass.
  assign swap     = sym_q ? pass_q : trn_q;
  assign dst_idx  = swap ? col_q : row_q;
  assign src_idx  = swap ? row_q : col_q;
  assign dst_ext  = EXT_W'(dst_idx);
  assign src_ext  = EXT_W'(src_idx);
  assign pass_ok  = (dst_ext < ACC_LIMIT) && (src_ext < VEC_LIMIT);
  assign second_pass = sym_q && !pass_q && (row_q != col_q);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q <= 1'b0;
      neg_q <= 1'b0;
      trn_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SYMMETRIC: sym_q <= cfg_data_i[0];
        REG_NEGATE:    neg_q <= cfg_data_i[0];
        REG_TRANSPOSE: trn_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    unique case (state_q)
      S_IDLE: begin
        pass_d = 1'b0;
        if (accept) begin
          unique case (in_op)
            OP_TRIPLET:  state_d = S_TR_READ;
            OP_READ_ACC: state_d = S_RD_WAIT;
            OP_LOAD_VEC, OP_SET_ACC: state_d = S_IDLE;
          endcase
        end
      end
      S_TR_READ: state_d = S_TR_MUL;
      S_TR_MUL:  state_d = S_TR_RND;
      S_TR_RND:  state_d = S_TR_ADD;
      S_TR_ADD: begin
        if (second_pass) begin
          state_d = S_TR_READ;
          pass_d  = 1'b1;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RD_WAIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs: memory ports, datapath enables and output load.
  always_comb begin
    in_i.ready      = 1'b0;
    vec_we          = 1'b0;
    vec_re          = 1'b0;
    acc_we          = 1'b0;
    acc_re          = 1'b0;
    acc_raddr       = dst_ext[AAW-1:0];
    acc_waddr       = dst_ext[AAW-1:0];
    acc_wdata       = mac_sum;
    out_load        = 1'b0;
    mac_ctrl.mul_en = 1'b0;
    mac_ctrl.rnd_en = 1'b0;
    mac_ctrl.negate = neg_q;
    unique case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        acc_raddr  = in_row_ext[AAW-1:0];
        acc_waddr  = in_row_ext[AAW-1:0];
        acc_wdata  = {{(ACC_W-VAL_W){in_i.operand_value[VAL_W-1]}}, in_i.operand_value};
        vec_we     = accept && (in_op == OP_LOAD_VEC) && in_vec_ok;
        acc_we     = accept && (in_op == OP_SET_ACC) && in_acc_ok;
        acc_re     = accept && (in_op == OP_READ_ACC) && in_acc_ok;
      end
      S_TR_READ: begin
        vec_re = 1'b1;
        acc_re = 1'b1;
      end
      S_TR_MUL:  mac_ctrl.mul_en = 1'b1;
      S_TR_RND:  mac_ctrl.rnd_en = 1'b1;
      S_TR_ADD:  acc_we = pass_ok;
      S_RD_WAIT: out_load = out_free;
      default: ;
    endcase
  end

  assign vec_waddr = in_row_ext[VAW-1:0];

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_d = out_load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  // Item payload captured at accept.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_q   <= in_i.row_index;
      col_q   <= in_i.column_index;
      value_q <= in_i.operand_value;
      rd_ok_q <= in_acc_ok;
    end
  end

  // Output register; an out-of-range read returns zero.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_index_q <= row_q;
      out_value_q <= rd_ok_q ? acc_rdata : '0;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.read_index = out_index_q;
  assign out_o.read_value = out_value_q;

  stmv_ram #(
    .WIDTH (VAL_W),
    .DEPTH (VECTOR_DEPTH)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (vec_we),
    .waddr_i (vec_waddr),
    .wdata_i (in_i.operand_value),
    .re_i    (vec_re),
    .raddr_i (src_ext[VAW-1:0]),
    .rdata_o (vec_rdata)
  );

  stmv_ram #(
    .WIDTH (ACC_W),
    .DEPTH (ACCUMULATOR_DEPTH)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .re_i    (acc_re),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  stmv_mac u_mac (
    .clk_i   (clk_i),
    .ctrl_i  (mac_ctrl),
    .value_i (value_q),
    .vec_i   (vec_rdata),
    .acc_i   (acc_rdata),
    .sum_o   (mac_sum)
  );

  // A result appears only after the accumulator read of a read item.
  a_out_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RD_WAIT))
    else $error("result item without a preceding accumulator read");

  // The mirrored pass happens only in symmetric mode for off-diagonal triplets.
  a_second_pass_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TR_READ && pass_q) |-> (sym_q && row_q != col_q))
    else $error("mirrored update outside symmetric off-diagonal case");

  // A triplet write-back follows the rounding stage directly.
  a_writeback_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TR_ADD) |-> $past(state_q == S_TR_RND))
    else $error("accumulator write-back out of sequence");

  // No item is taken while a triplet or read is still in progress.
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TR_MUL || state_q == S_TR_RND || state_q == S_RD_WAIT) |-> !accept)
    else $error("item accepted while the sequencer is busy");

endmodule

>>> verif/tb.sv
// Self-checking testbench for the sparse triplet matrix-vector multiply block.
// Depends on stmv_pkg, the stmv_in_if / stmv_out_if interfaces and the block itself;
// a scoreboard class predicts every accumulator read and checks the returned items.
module tb;
  import stmv_pkg::*;

  localparam int unsigned DEPTH          = 1024;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned PHASE_ITEMS    = 132;
  localparam int unsigned SETTLE_CYCLES  = 20;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned LIMIT_CYCLES   = 400000;
  localparam longint      ACC_MAX        = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint      ACC_MIN        = -ACC_MAX - 1;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  // One expected accumulator read item.
  typedef struct {
    logic [IDX_W-1:0]        index;
    logic signed [ACC_W-1:0] value;
  } acc_read_t;

  // Mirrors the vector and accumulator stores and queues the expected read items.
  class spmv_scoreboard;
    logic signed [VAL_W-1:0] vec_mem [DEPTH];
    logic signed [ACC_W-1:0] acc_mem [DEPTH];
    bit                      symmetric;
    bit                      negate;
    bit                      transpose;
    acc_read_t               expected_reads [$];
    int unsigned             errors;
    int unsigned             reads_checked;
    int unsigned             items_seen;
    int unsigned             triplets_seen;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, bit data);
      case (idx)
        REG_SYMMETRIC: symmetric = data;
        REG_NEGATE:    negate = data;
        REG_TRANSPOSE: transpose = data;
        default: ;
      endcase
    endfunction

    // Product of Q16.16 values rounded to Q32.16, optionally negated, added with saturation.
    function void accumulate_product(int unsigned dst, int unsigned src,
                                     logic signed [VAL_W-1:0] value);
      longint prod;
      longint term;
      longint sum;
      prod = longint'(value) * longint'(vec_mem[src]);
      term = (prod + ROUND_HALF) >>> FRAC_SHIFT;
      if (negate) begin
        term = -term;
      end
      sum = longint'(acc_mem[dst]) + term;
      if (sum > ACC_MAX) begin
        sum = ACC_MAX;
      end else if (sum < ACC_MIN) begin
        sum = ACC_MIN;
      end
      acc_mem[dst] = sum[ACC_W-1:0];
    endfunction

    function void take_item(opcode_e op, int unsigned row, int unsigned col,
                            logic signed [VAL_W-1:0] value);
      acc_read_t rd;
      items_seen++;
      case (op)
        OP_LOAD_VEC: vec_mem[row] = value;
        OP_SET_ACC:  acc_mem[row] = ACC_W'(value);
        OP_TRIPLET: begin
          triplets_seen++;
          if (symmetric) begin
            accumulate_product(row, col, value);
            if (row != col) begin
              accumulate_product(col, row, value);
            end
          end else if (transpose) begin
            accumulate_product(col, row, value);
          end else begin
            accumulate_product(row, col, value);
          end
        end
        default: begin
          rd.index = IDX_W'(row);
          rd.value = acc_mem[row];
          expected_reads = {expected_reads, rd};
        end
      endcase
    endfunction

    function void check_read(logic [IDX_W-1:0] index, logic signed [ACC_W-1:0] value);
      acc_read_t rd;
      if (expected_reads.size() == 0) begin
        $display("%0t: read item with none expected: index %0d value %0d",
                 $time, index, value);
        errors++;
        return;
      end
      rd = expected_reads.pop_front();
      reads_checked++;
      if (index !== rd.index) begin
        $display("%0t: read_index mismatch: expected %0d actual %0d", $time, rd.index, index);
        errors++;
      end
      if (value !== rd.value) begin
        $display("%0t: read_value mismatch at index %0d: expected %0d actual %0d",
                 $time, rd.index, rd.value, value);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_reads.size();
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  stmv_in_if  in_if ();
  stmv_out_if out_if ();

  sparse_triplet_matrix_vector_multiply dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  spmv_scoreboard sb = new();

  // Idling controls for the sender and the receiver.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;
  int unsigned settings_used = 0;

  // Entries written so far; triplets and reads only touch these.
  bit          vec_ok [DEPTH];
  bit          acc_ok [DEPTH];
  int unsigned vec_list [$];
  int unsigned acc_list [$];
  int unsigned both_list [$];

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watch both channels and feed the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      sb.take_item(opcode_e'(in_if.opcode), in_if.row_index, in_if.column_index,
                   in_if.operand_value);
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_read(out_if.read_index, out_if.read_value);
    end
  end

  function automatic int unsigned pick_index(int unsigned q [$]);
    return q[$urandom_range(q.size() - 1)];
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(3))
      0: return $urandom();
      1: begin
        case ($urandom_range(4))
          0: return VAL_MAX;
          1: return VAL_MIN;
          2: return '0;
          3: return -1;
          default: return 1;
        endcase
      end
      default: return $signed($urandom_range(262143)) - 131072;
    endcase
  endfunction

  // Offer one item after random idle cycles and wait for it to be taken.
  task automatic drive_item(opcode_e op, int unsigned row, int unsigned col,
                            logic signed [VAL_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.opcode        <= op;
    in_if.row_index     <= IDX_W'(row);
    in_if.column_index  <= IDX_W'(col);
    in_if.operand_value <= value;
    @(posedge clk_i);
    while (!in_if.ready) begin
      @(posedge clk_i);
    end
    // Track which entries are now safe to read.
    if (op == OP_LOAD_VEC && !vec_ok[row]) begin
      vec_ok[row] = 1'b1;
      vec_list = {vec_list, row};
      if (acc_ok[row]) begin
        both_list = {both_list, row};
      end
    end else if (op == OP_SET_ACC && !acc_ok[row]) begin
      acc_ok[row] = 1'b1;
      acc_list = {acc_list, row};
      if (vec_ok[row]) begin
        both_list = {both_list, row};
      end
    end
  endtask

  // Stop offering items until every expected read has come back.
  task automatic pause_until_empty(int unsigned settle);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, bit data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic load_config(bit sym, bit neg, bit tr);
    cfg_write(REG_SYMMETRIC, sym);
    cfg_write(REG_NEGATE, neg);
    cfg_write(REG_TRANSPOSE, tr);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Edge values, saturation in both directions and rounding ties.
  task automatic run_directed();
    drive_item(OP_LOAD_VEC, 0, 1023, VAL_MIN);
    drive_item(OP_LOAD_VEC, 1023, 0, VAL_MAX);
    drive_item(OP_LOAD_VEC, 1, 0, '0);
    drive_item(OP_LOAD_VEC, 2, 0, -1);
    drive_item(OP_LOAD_VEC, 3, 0, 1);
    drive_item(OP_SET_ACC, 0, 1023, VAL_MAX);
    drive_item(OP_SET_ACC, 1023, 0, VAL_MIN);
    drive_item(OP_SET_ACC, 1, 0, '0);
    drive_item(OP_SET_ACC, 2, 0, -1);
    drive_item(OP_READ_ACC, 0, 0, '0);
    drive_item(OP_READ_ACC, 1023, 1023, VAL_MIN);
    // Largest positive product twice drives the accumulator into positive saturation.
    drive_item(OP_TRIPLET, 0, 0, VAL_MIN);
    drive_item(OP_TRIPLET, 0, 0, VAL_MIN);
    drive_item(OP_READ_ACC, 0, 0, '0);
    // Largest negative product twice saturates the other way.
    drive_item(OP_TRIPLET, 1023, 0, VAL_MAX);
    drive_item(OP_TRIPLET, 1023, 0, VAL_MAX);
    drive_item(OP_READ_ACC, 1023, 0, '0);
    // Half-LSB ties round upward; just below minus one half rounds down.
    drive_item(OP_TRIPLET, 1, 3, 32'sh0000_8000);
    drive_item(OP_TRIPLET, 2, 2, 32'sh0000_8000);
    drive_item(OP_TRIPLET, 1, 3, -32769);
    drive_item(OP_TRIPLET, 1, 1023, 1);
    drive_item(OP_TRIPLET, 2, 1, VAL_MAX);
    drive_item(OP_READ_ACC, 1, 0, '0);
    drive_item(OP_READ_ACC, 2, 0, '0);
  endtask

  task automatic random_item();
    int unsigned pick;
    int unsigned r;
    int unsigned c;
    pick = $urandom_range(99);
    if (pick < 10) begin
      drive_item(OP_LOAD_VEC, $urandom_range(DEPTH - 1), $urandom_range(DEPTH - 1),
                 rand_value());
    end else if (pick < 20) begin
      drive_item(OP_SET_ACC, $urandom_range(DEPTH - 1), $urandom_range(DEPTH - 1),
                 rand_value());
    end else if (pick < 27) begin
      // Prime a random entry in both stores so later triplets can use it.
      r = $urandom_range(DEPTH - 1);
      drive_item(OP_LOAD_VEC, r, $urandom_range(DEPTH - 1), rand_value());
      drive_item(OP_SET_ACC, r, $urandom_range(DEPTH - 1), rand_value());
    end else if (pick < 72) begin
      if (sb.symmetric) begin
        r = pick_index(both_list);
        c = ($urandom_range(4) == 0) ? r : pick_index(both_list);
      end else if (sb.transpose) begin
        r = pick_index(vec_list);
        c = pick_index(acc_list);
      end else begin
        r = pick_index(acc_list);
        c = pick_index(vec_list);
      end
      drive_item(OP_TRIPLET, r, c, rand_value());
    end else begin
      drive_item(OP_READ_ACC, pick_index(acc_list), $urandom_range(DEPTH - 1), $urandom());
    end
  endtask

  task automatic set_idling(int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 66; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 66; end
      default: begin send_idle_pct = 11; stall_pct = 11; end
    endcase
  endtask

  // Register settings per phase: symmetric, negate, transpose.
  bit [2:0] phase_cfg [PHASES] = '{3'b000, 3'b100, 3'b010, 3'b001,
                                   3'b111, 3'b011, 3'b110, 3'b101};

  initial begin
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    in_if.valid         = 1'b0;
    in_if.opcode        = '0;
    in_if.row_index     = '0;
    in_if.column_index  = '0;
    in_if.operand_value = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      pause_until_empty(SETTLE_CYCLES);
      load_config(phase_cfg[ph][2], phase_cfg[ph][1], phase_cfg[ph][0]);
      set_idling(ph % 4);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        // Long receiver hold-off while items keep coming, so the block backs up.
        if (ph == 4 && n == 10) begin
          hold_request = HOLD_CYCLES;
        end
        // Sender waits for every outstanding read before going on.
        if (ph == 6 && n == 60) begin
          pause_until_empty(0);
        end
        random_item();
      end
    end

    pause_until_empty(SETTLE_CYCLES);
    $display("Sent %0d input items (%0d triplets) under %0d register settings.",
             sb.items_seen, sb.triplets_seen, settings_used);
    $display("Checked %0d accumulator read items; %0d mismatches.",
             sb.reads_checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(12 * LIMIT_CYCLES);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
